// ===== rtl/core/mqfb_pkg.sv =====
// ============================================================================
// mqfb_pkg - shared constants, types and helpers of the multi-queue FIFO bank
// Sizes of the queue bank, operation and status codes, entry address math.
// ============================================================================
package mqfb_pkg;

    localparam int NUM_QUEUES  = 5;
    localparam int QUEUE_DEPTH = 16;

    localparam int QIDX_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int KIND_W   = 2;
    localparam int QNUM_W   = 3;
    localparam int STATUS_W = 2;
    localparam int TICKET_W = 32;

    typedef logic [QIDX_W-1:0]   t_qidx;
    typedef logic [PTR_W-1:0]    t_ptr;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [QNUM_W-1:0]   t_qnum;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [TICKET_W-1:0] t_ticket;

    localparam t_ticket TICKET_START = t_ticket'(10);

    localparam t_kind KIND_ENQ   = 2'd0;
    localparam t_kind KIND_DEQ   = 2'd1;
    localparam t_kind KIND_DRAIN = 2'd2;

    localparam t_status ST_ENQUEUED = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_SERVED   = 2'd2;
    localparam t_status ST_EMPTY    = 2'd3;

    // Flat entry address: queue base plus slot.
    function automatic t_addr entry_addr(input t_qidx q, input t_ptr p);
        return ADDR_W'(int'(q) * QUEUE_DEPTH + int'(p));
    endfunction

    // Advance a slot pointer, wrapping at the queue depth.
    function automatic t_ptr next_ptr(input t_ptr p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

// ===== rtl/core/mqfb_ram.sv =====
// ============================================================================
// mqfb_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module mqfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/multi_queue_fifo_bank_top.sv =====
// ============================================================================
// multi_queue_fifo_bank_top - bank of independent bounded ticket queues
// Enqueue stores a fresh ticket from a shared counter, dequeue serves the
// oldest entry, drain serves every entry of a queue oldest first.
// ============================================================================
//
//  channel | direction | handshake              | words
//  --------+-----------+------------------------+-------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_kind, i_queue_index
//  out     | from block| o_out_valid / i_out_stall| o_status, o_queue_number,
//          |           |                        | o_ticket, o_last
//
//  Sequence: enqueue, full, empty and ignored words are handled while idle. A
//  dequeue that serves an entry reads the entry RAM while idle and loads the
//  result register in the data state. A drain reads its first entry while
//  idle and the rest in the issue state, and loads each in the data state.
//  Reset: synchronous, active low; clears pointers, fill counts, the state
//  and the result register's valid; the ticket counter restarts at ten.
//  The entry RAM is not cleared: fill counts guard every read.
//  Stalls: one result register on the output; a new word is taken while the
//  last result is being taken. Output stall holds the sequencer before reads.
// ============================================================================
module multi_queue_fifo_bank_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  mqfb_pkg::t_kind          i_kind,
    input  logic [2:0]               i_queue_index,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output mqfb_pkg::t_status        o_status,
    output mqfb_pkg::t_qnum          o_queue_number,
    output mqfb_pkg::t_ticket        o_ticket,
    output logic                     o_last
);

    import mqfb_pkg::*;

    // Sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;  // take a word
    localparam logic [1:0] S_ISSUE = 2'd1;  // drain: wait for room, then read
    localparam logic [1:0] S_DATA  = 2'd2;  // RAM word arrives, load result

    logic [1:0] r_state, n_state;
    t_ptr       r_head  [NUM_QUEUES];
    t_ptr       n_head  [NUM_QUEUES];
    t_ptr       r_tail  [NUM_QUEUES];
    t_ptr       n_tail  [NUM_QUEUES];
    t_cnt       r_count [NUM_QUEUES];
    t_cnt       n_count [NUM_QUEUES];
    t_ticket    r_ticket, n_ticket;
    t_qidx      r_q, n_q;
    logic       r_deq, n_deq;

    // Result register
    logic       r_out_valid, n_out_valid;
    t_status    r_status, n_status;
    t_qnum      r_qnum, n_qnum;
    t_ticket    r_out_ticket, n_out_ticket;
    logic       r_last, n_last;

    // Entry RAM ports
    logic       ram_we, ram_re;
    t_addr      ram_waddr, ram_raddr;
    t_ticket    ram_rdata;

    logic       out_free, in_acc, in_range, enq_ok;
    t_qidx      q_in;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_range   = int'(i_queue_index) < NUM_QUEUES;
    assign q_in       = QIDX_W'(i_queue_index);
    assign enq_ok     = in_acc && in_range && (i_kind == KIND_ENQ)
                        && (r_count[q_in] < CNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_ticket     = r_ticket;
        n_q          = r_q;
        n_deq        = r_deq;
        n_out_valid  = r_out_valid && i_out_stall;  // drop once taken
        n_status     = r_status;
        n_qnum       = r_qnum;
        n_out_ticket = r_out_ticket;
        n_last       = r_last;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = '0;
        ram_raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && in_range) begin
                    case (i_kind)
                        KIND_ENQ: begin
                            n_out_valid = 1'b1;
                            n_qnum      = i_queue_index;
                            n_last      = 1'b1;
                            if (enq_ok) begin
                                n_ticket       = r_ticket + TICKET_W'(1);
                                ram_we         = 1'b1;
                                ram_waddr      = entry_addr(q_in, r_tail[q_in]);
                                n_tail[q_in]   = next_ptr(r_tail[q_in]);
                                n_count[q_in]  = r_count[q_in] + CNT_W'(1);
                                n_status       = ST_ENQUEUED;
                                n_out_ticket   = n_ticket;
                            end else begin
                                n_status     = ST_FULL;
                                n_out_ticket = '0;
                            end
                        end
                        KIND_DEQ: begin
                            if (r_count[q_in] == '0) begin
                                n_out_valid  = 1'b1;
                                n_status     = ST_EMPTY;
                                n_qnum       = i_queue_index;
                                n_out_ticket = '0;
                                n_last       = 1'b1;
                            end else begin
                                // Pop now, data shows up next cycle
                                ram_re        = 1'b1;
                                ram_raddr     = entry_addr(q_in, r_head[q_in]);
                                n_head[q_in]  = next_ptr(r_head[q_in]);
                                n_count[q_in] = r_count[q_in] - CNT_W'(1);
                                n_q           = q_in;
                                n_deq         = 1'b1;
                                n_state       = S_DATA;
                            end
                        end
                        KIND_DRAIN: begin
                            if (r_count[q_in] != '0) begin
                                ram_re        = 1'b1;
                                ram_raddr     = entry_addr(q_in, r_head[q_in]);
                                n_head[q_in]  = next_ptr(r_head[q_in]);
                                n_count[q_in] = r_count[q_in] - CNT_W'(1);
                                n_q           = q_in;
                                n_deq         = 1'b0;
                                n_state       = S_DATA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                // Read only when the result register will be empty on arrival
                if (out_free) begin
                    ram_re       = 1'b1;
                    ram_raddr    = entry_addr(r_q, r_head[r_q]);
                    n_head[r_q]  = next_ptr(r_head[r_q]);
                    n_count[r_q] = r_count[r_q] - CNT_W'(1);
                    n_state      = S_DATA;
                end
            end
            S_DATA: begin
                n_out_valid  = 1'b1;
                n_status     = ST_SERVED;
                n_qnum       = QNUM_W'(r_q);
                n_out_ticket = ram_rdata;
                n_last       = r_deq || (r_count[r_q] == '0);
                n_state      = (r_deq || (r_count[r_q] == '0)) ? S_IDLE : S_ISSUE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ticket    <= TICKET_START;
            r_q         <= '0;
            r_deq       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ticket    <= n_ticket;
            r_q         <= n_q;
            r_deq       <= n_deq;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
        end
    end

    // Result payload, no reset
    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_qnum       <= n_qnum;
        r_out_ticket <= n_out_ticket;
        r_last       <= n_last;
    end

    mqfb_ram #(
        .WIDTH (TICKET_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (n_ticket),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_queue_number = r_qnum;
    assign o_ticket       = r_out_ticket;
    assign o_last         = r_last;

    // A RAM word must never land on a pending result
    a_data_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> !r_out_valid)
        else $error("RAM word arrives while result register is occupied");

    // Fill count of the active queue stays within the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[r_q] <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count exceeds queue depth");

    // A served entry that empties the queue ends the operation
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA && r_count[r_q] == '0) |=> (r_state == S_IDLE && r_last))
        else $error("drain did not end on the final entry");

    // Successful enqueue advances the ticket counter by one and reports it
    a_ticket_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        enq_ok |=> (r_ticket == $past(r_ticket) + TICKET_W'(1)
                    && r_out_ticket == r_ticket && r_out_valid))
        else $error("ticket counter did not advance on enqueue");

    // Counter holds on anything but a successful enqueue
    a_ticket_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !enq_ok |=> $stable(r_ticket))
        else $error("ticket counter moved without an enqueue");

endmodule
